// ===== design/atrp_pkg.sv =====
// atrp_pkg: widths, constants, types and the arctangent table shared by the
// tilt angle design. Depends on nothing.
package atrp_pkg;

  // sample and intermediate widths
  localparam int SAMPLE_BITS  = 16;
  localparam int SQ_W         = 2 * SAMPLE_BITS;
  localparam int NORM_EXP     = 60;
  localparam int K_MAX        = NORM_EXP / 2;
  localparam int K_W          = $clog2(K_MAX + 1);
  localparam int RAD_W        = NORM_EXP + 1;
  localparam int ISQ_W        = RAD_W + 1;
  localparam int ISQ_STEPS    = NORM_EXP / 2 + 1;
  localparam int ROOT_W       = NORM_EXP / 2 + 1;
  localparam int NUM_W        = NORM_EXP / 2 + 2;
  localparam int VEC_W        = NORM_EXP / 2 + 4;

  // cordic and angle format
  localparam int CORDIC_STEPS = 23;
  localparam int ACC_W        = 26;
  localparam int TAB_W        = 24;
  localparam int ANGLE_W      = 16;
  localparam int RND_SHIFT    = 8;
  localparam int R_W          = ACC_W - RND_SHIFT;
  localparam int ANGLE_LIMIT  = 23040;
  localparam int BACK_LAT     = ISQ_STEPS + CORDIC_STEPS;

  // atan(2^-i) in 1/65536 degree
  localparam logic [TAB_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'd2949120, 24'd1740967, 24'd919879, 24'd466945, 24'd234379, 24'd117304,
    24'd58666, 24'd29335, 24'd14668, 24'd7334, 24'd3667, 24'd1833, 24'd917,
    24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14, 24'd7, 24'd4, 24'd2,
    24'd1
  };

  // one angle job: scaled squared denominator and scaled numerator
  typedef struct packed {
    logic [RAD_W-1:0]        rad;
    logic signed [NUM_W-1:0] num;
    logic                    zero;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
  } job_t;

endpackage

// ===== design/atrp_front.sv =====
// atrp_front: registers samples, forms squares, picks the scale and builds
// both angle jobs. Depends on atrp_pkg.
module atrp_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_x_i,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_y_i,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_z_i,
  output logic                                   job_valid_o,
  output atrp_pkg::job_t                         job_o,
  input  logic                                   job_full_i
);
  import atrp_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;
  logic signed [SAMPLE_BITS-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, x3_q, y3_q;
  logic [SQ_W-1:0] xx2_q, yy2_q, zz2_q;
  logic signed [SQ_W-1:0] px, py, pz;
  logic [SQ_W-1:0] tot, dr, dp, dr3_q, dp3_q;
  logic [K_MAX:1] fits;
  logic [K_W-1:0] k_d, k3_q;
  job_t job_d, job4_q;

  // whole front moves together unless the queue is backed up
  assign adv  = !v4_q || !job_full_i;
  assign full = !adv;

  assign px = x1_q * x1_q;
  assign py = y1_q * y1_q;
  assign pz = z1_q * z1_q;

  assign tot = xx2_q + yy2_q + zz2_q;
  assign dr  = yy2_q + zz2_q;
  assign dp  = xx2_q + zz2_q;

  // scale: largest k with total * 4^k within 2^NORM_EXP
  always_comb begin
    for (int j = 1; j <= K_MAX; j++) begin
      fits[j] = (RAD_W'(tot) <= (RAD_W'(1) << (NORM_EXP - 2 * j)));
    end
    k_d = K_W'($countones(fits));
  end

  // shift both lanes by the scale
  always_comb begin
    job_d.roll.rad   = RAD_W'(dr3_q) << (2 * k3_q);
    job_d.roll.num   = NUM_W'(x3_q) <<< k3_q;
    job_d.roll.zero  = (dr3_q == '0);
    job_d.pitch.rad  = RAD_W'(dp3_q) << (2 * k3_q);
    job_d.pitch.num  = NUM_W'(y3_q) <<< k3_q;
    job_d.pitch.zero = (dp3_q == '0);
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q   <= acc_x_i;
      y1_q   <= acc_y_i;
      z1_q   <= acc_z_i;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      xx2_q  <= $unsigned(px);
      yy2_q  <= $unsigned(py);
      zz2_q  <= $unsigned(pz);
      x3_q   <= x2_q;
      y3_q   <= y2_q;
      dr3_q  <= dr;
      dp3_q  <= dp;
      k3_q   <= k_d;
      job4_q <= job_d;
    end
  end

  assign job_valid_o = v4_q;
  assign job_o       = job4_q;

endmodule

// ===== design/atrp_queue.sv =====
// atrp_queue: two-entry job queue between front and back.
// Depends on atrp_pkg.
module atrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  atrp_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output atrp_pkg::job_t rdata_o
);
  import atrp_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

// ===== design/atrp_isqrt.sv =====
// atrp_isqrt: pipelined integer square root, one result bit per stage,
// carrying the numerator alongside. Depends on atrp_pkg.
module atrp_isqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  atrp_pkg::lane_t                   lane_i,
  output logic [atrp_pkg::ROOT_W-1:0]       root_o,
  output logic signed [atrp_pkg::NUM_W-1:0] num_o,
  output logic                              zero_o
);
  import atrp_pkg::*;

  logic [ISQ_W-1:0]        s_q   [ISQ_STEPS];
  logic [ISQ_W-1:0]        res_q [ISQ_STEPS];
  logic signed [NUM_W-1:0] num_q [ISQ_STEPS];
  logic                    zero_q[ISQ_STEPS];

  for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_step
    localparam logic [ISQ_W-1:0] Bit = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - i));
    logic [ISQ_W-1:0]        s_in, res_in;
    logic signed [NUM_W-1:0] num_in;
    logic                    zero_in;
    logic [ISQ_W:0]          trial;
    logic                    take;

    if (i == 0) begin : g_first
      assign s_in    = {1'b0, lane_i.rad};
      assign res_in  = '0;
      assign num_in  = lane_i.num;
      assign zero_in = lane_i.zero;
    end else begin : g_next
      assign s_in    = s_q[i-1];
      assign res_in  = res_q[i-1];
      assign num_in  = num_q[i-1];
      assign zero_in = zero_q[i-1];
    end

    // restoring step: subtract when the trial fits
    assign trial = {1'b0, res_in} + {1'b0, Bit};
    assign take  = ({1'b0, s_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[i]    <= take ? (s_in - trial[ISQ_W-1:0]) : s_in;
        res_q[i]  <= take ? ((res_in >> 1) + Bit) : (res_in >> 1);
        num_q[i]  <= num_in;
        zero_q[i] <= zero_in;
      end
    end
  end

  assign root_o = res_q[ISQ_STEPS-1][ROOT_W-1:0];
  assign num_o  = num_q[ISQ_STEPS-1];
  assign zero_o = zero_q[ISQ_STEPS-1];

endmodule

// ===== design/atrp_cordic.sv =====
// atrp_cordic: pipelined vectoring cordic, one rotation per stage, giving the
// angle in 1/65536 degree. Depends on atrp_pkg.
module atrp_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [atrp_pkg::ROOT_W-1:0]       root_i,
  input  logic signed [atrp_pkg::NUM_W-1:0] num_i,
  input  logic                              zero_i,
  output logic signed [atrp_pkg::ACC_W-1:0] acc_o,
  output logic                              zero_o,
  output logic                              neg_o,
  output logic                              nz_o
);
  import atrp_pkg::*;

  logic signed [VEC_W-1:0] vx_q [CORDIC_STEPS];
  logic signed [VEC_W-1:0] vy_q [CORDIC_STEPS];
  logic signed [ACC_W-1:0] acc_q[CORDIC_STEPS];
  logic                    zero_q[CORDIC_STEPS];
  logic                    neg_q [CORDIC_STEPS];
  logic                    nz_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ACC_W-1:0] Ang = ACC_W'(ATAN_TAB[i]);
    logic signed [VEC_W-1:0] vx_in, vy_in, dx, dy;
    logic signed [ACC_W-1:0] acc_in;
    logic                    zero_in, neg_in, nz_in;

    if (i == 0) begin : g_first
      assign vx_in   = $signed({(VEC_W - ROOT_W)'(0), root_i});
      assign vy_in   = VEC_W'(num_i);
      assign acc_in  = '0;
      assign zero_in = zero_i;
      assign neg_in  = num_i[NUM_W-1];
      assign nz_in   = (num_i != '0);
    end else begin : g_next
      assign vx_in   = vx_q[i-1];
      assign vy_in   = vy_q[i-1];
      assign acc_in  = acc_q[i-1];
      assign zero_in = zero_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign nz_in   = nz_q[i-1];
    end

    assign dx = vy_in >>> i;
    assign dy = vx_in >>> i;

    // rotate toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (vy_in > 0) begin
          vx_q[i]  <= vx_in + dx;
          vy_q[i]  <= vy_in - dy;
          acc_q[i] <= acc_in + Ang;
        end else begin
          vx_q[i]  <= vx_in - dx;
          vy_q[i]  <= vy_in + dy;
          acc_q[i] <= acc_in - Ang;
        end
        zero_q[i] <= zero_in;
        neg_q[i]  <= neg_in;
        nz_q[i]   <= nz_in;
      end
    end
  end

  assign acc_o  = acc_q[CORDIC_STEPS-1];
  assign zero_o = zero_q[CORDIC_STEPS-1];
  assign neg_o  = neg_q[CORDIC_STEPS-1];
  assign nz_o   = nz_q[CORDIC_STEPS-1];

endmodule

// ===== design/atrp_back.sv =====
// atrp_back: square root and cordic lanes for roll and pitch, rounding and
// the output register. Depends on atrp_pkg, atrp_isqrt and atrp_cordic.
module atrp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  input  atrp_pkg::job_t                      job_i,
  output logic                                job_pop_o,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [atrp_pkg::ANGLE_W-1:0] roll_angle_o,
  output logic signed [atrp_pkg::ANGLE_W-1:0] pitch_angle_o
);
  import atrp_pkg::*;

  logic                    adv;
  logic [BACK_LAT-1:0]     vld_q;
  logic                    out_vld_q;
  logic signed [ANGLE_W-1:0] roll_q, pitch_q, roll_d, pitch_d;

  logic [ROOT_W-1:0]       r_root, p_root;
  logic signed [NUM_W-1:0] r_num, p_num;
  logic                    r_zero_s, p_zero_s;
  logic signed [ACC_W-1:0] r_acc, p_acc;
  logic                    r_zero, r_neg, r_nz, p_zero, p_neg, p_nz;

  function automatic logic signed [ANGLE_W-1:0] finish(
    input logic signed [ACC_W-1:0] acc,
    input logic zero, input logic neg, input logic nz
  );
    logic signed [ACC_W-1:0] sum;
    logic signed [R_W-1:0]   r;
    sum = acc + ACC_W'(1 << (RND_SHIFT - 1));
    r   = R_W'(sum >>> RND_SHIFT);
    if (zero) begin
      if (!nz)      r = '0;
      else if (neg) r = -R_W'(ANGLE_LIMIT);
      else          r = R_W'(ANGLE_LIMIT);
    end else if (r > R_W'(ANGLE_LIMIT)) begin
      r = R_W'(ANGLE_LIMIT);
    end else if (r < -R_W'(ANGLE_LIMIT)) begin
      r = -R_W'(ANGLE_LIMIT);
    end
    return r[ANGLE_W-1:0];
  endfunction

  // the whole back moves when the output register is free or being taken
  assign adv       = !out_vld_q || pop;
  assign job_pop_o = adv && job_valid_i;
  assign empty     = !out_vld_q;

  atrp_isqrt u_isqrt_roll (
    .clk_i (clk_i), .en_i (adv), .lane_i (job_i.roll),
    .root_o(r_root), .num_o(r_num), .zero_o(r_zero_s)
  );

  atrp_isqrt u_isqrt_pitch (
    .clk_i (clk_i), .en_i (adv), .lane_i (job_i.pitch),
    .root_o(p_root), .num_o(p_num), .zero_o(p_zero_s)
  );

  atrp_cordic u_cordic_roll (
    .clk_i (clk_i), .en_i (adv), .root_i(r_root), .num_i(r_num),
    .zero_i(r_zero_s), .acc_o(r_acc), .zero_o(r_zero), .neg_o(r_neg),
    .nz_o  (r_nz)
  );

  atrp_cordic u_cordic_pitch (
    .clk_i (clk_i), .en_i (adv), .root_i(p_root), .num_i(p_num),
    .zero_i(p_zero_s), .acc_o(p_acc), .zero_o(p_zero), .neg_o(p_neg),
    .nz_o  (p_nz)
  );

  assign roll_d  = finish(r_acc, r_zero, r_neg, r_nz);
  assign pitch_d = finish(p_acc, p_zero, p_neg, p_nz);

  // valid chain and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[BACK_LAT-2:0], job_valid_i};
      out_vld_q <= vld_q[BACK_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
    end
  end

  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;

endmodule

// ===== design/accel_tilt_roll_pitch.sv =====
// accel_tilt_roll_pitch: top level of the tilt angle block, front, job queue
// and back. Depends on atrp_pkg, atrp_front, atrp_queue and atrp_back.
//
//   channel  | handshake    | beat
//   sample   | push / full  | acc_x_i, acc_y_i, acc_z_i
//   angles   | pop / empty  | roll_angle_o, pitch_angle_o
//
// One sample per cycle sustained while nothing stalls; a sample passes through
// 4 front stages, a 2-entry queue pass, 31 square root stages, 23 cordic
// stages and the output register.
// The back advances as one pipeline whenever the output register is empty or
// popped; a held result stalls the back, the queue then fills and full rises.
// Reset clears only valid bits, queue pointers and the queue fill count.
module accel_tilt_roll_pitch (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_x_i,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_y_i,
  input  logic signed [atrp_pkg::SAMPLE_BITS-1:0] acc_z_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [atrp_pkg::ANGLE_W-1:0]    roll_angle_o,
  output logic signed [atrp_pkg::ANGLE_W-1:0]    pitch_angle_o
);
  import atrp_pkg::*;

  logic f_valid, q_full, q_empty, q_pop;
  job_t f_job, q_job;

  atrp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .acc_x_i    (acc_x_i),
    .acc_y_i    (acc_y_i),
    .acc_z_i    (acc_z_i),
    .job_valid_o(f_valid),
    .job_o      (f_job),
    .job_full_i (q_full)
  );

  atrp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid && !q_full),
    .wdata_i(f_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_job)
  );

  atrp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_empty),
    .job_i        (q_job),
    .job_pop_o    (q_pop),
    .empty        (empty),
    .pop          (pop),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

endmodule
